### rtl/double_ended_queue_defines.svh
// Assertion macros for the double-ended queue checker.
// Used by deq_checker.sv only; no other dependencies.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Clocked assertion, switched off while reset is held
`define DEQ_ASSERT(lbl, prop) lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
    prop) else $error("deque checker: property failed");

// Clocked assertion that also runs through reset
`define DEQ_ASSERT_RST(lbl, prop) lbl: assert property (@(posedge i_clk) prop) \
    else $error("deque checker: reset property failed");

`endif

### rtl/deq_pkg.sv
// Shared types and constants for the double-ended queue.
// No dependencies; imported by every deq_* module and the top level.
package deq_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // output tdata layout, lowest bit first
    localparam int REMOVED_LSB = 0;
    localparam int FRONT_LSB   = REMOVED_LSB + DATA_W;
    localparam int LAST_LSB    = FRONT_LSB + DATA_W;
    localparam int COUNT_LSB   = LAST_LSB + DATA_W;
    localparam int EMPTY_BIT   = COUNT_LSB + CNT_W;
    localparam int FULL_BIT    = EMPTY_BIT + 1;
    localparam int OUT_FIELD_W = FULL_BIT + 1;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        REQ_PUSH_BACK  = 2'd0,
        REQ_PUSH_FRONT = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_BACK   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        t_req                     req;
        logic signed [DATA_W-1:0] value;
    } t_req_item;

    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] removed;
        logic signed [DATA_W-1:0] front;
        logic signed [DATA_W-1:0] last;
        logic [CNT_W-1:0]         count;
        logic                     empty;
        logic                     full;
    } t_result;

endpackage

### rtl/double_ended_queue.sv
// Double-ended queue of signed 32-bit values, 16 entries deep.
// Depends on deq_pkg, deq_in_reg, deq_store and deq_out_reg.
//
// Usage notes
// - Slave stream (i_s_*): one request item per handshake. tuser carries the
//   operation (push back, push front, pop front, pop back), tdata the value
//   to push, ignored on pops.
// - Master stream (o_m_*): exactly one result item per request, in order.
//   tuser carries the status (done, refused full, refused empty), tdata the
//   removed value, front and back entries, entry count and empty/full flags.
// - Path: a taken request passes the input register, then the update logic,
//   then the result register.
// - Throughput: one request per cycle while the receiver does not stall; the
//   only feedback is the slot shift registers and occupancy counter.
// - Receiver stall: the result register holds its item; the input register
//   still takes one more request, after which o_s_tready drops.
// - Reset (i_rst_n low, synchronous): both registers empty, queue empty.
//   Slot contents are not cleared; only written slots are ever read.
module double_ended_queue
    import deq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [DATA_W-1:0]     i_s_tdata,   // [31:0] push_value
    input  logic [1:0]            i_s_tuser,   // [1:0] req_type
    // result stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [31:0] removed_value, [63:32] front_value, [95:64] last_value,
    // [100:96] entry_count, [101] is_empty, [102] is_full, rest zero
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic [1:0]            o_m_tuser    // [1:0] status
);

    t_req_item s_item;
    t_req_item req_item;
    t_result   upd_result;
    t_result   out_result;
    logic      req_valid;
    logic      out_free;
    logic      advance;

    assign s_item.req   = t_req'(i_s_tuser);
    assign s_item.value = i_s_tdata;

    // a held request is processed once the result register has room
    assign advance = req_valid && out_free;

    deq_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .i_item    (s_item),
        .i_advance (advance),
        .o_ready   (o_s_tready),
        .o_valid   (req_valid),
        .o_item    (req_item)
    );

    deq_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (req_item),
        .o_result  (upd_result)
    );

    deq_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (upd_result),
        .i_ready  (i_m_tready),
        .o_free   (out_free),
        .o_valid  (o_m_tvalid),
        .o_result (out_result)
    );

    logic [OUT_FIELD_W-1:0] out_fields;

    assign out_fields = {out_result.full, out_result.empty, out_result.count,
                         out_result.last, out_result.front, out_result.removed};
    assign o_m_tdata  = OUT_DATA_W'(out_fields);
    assign o_m_tuser  = out_result.status;

endmodule

### rtl/deq_in_reg.sv
// Input register of the double-ended queue: holds one request item.
// Depends on deq_pkg.
module deq_in_reg
    import deq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_req_item i_item,
    input  logic      i_advance,
    output logic      o_ready,
    output logic      o_valid,
    output t_req_item o_item
);

    logic      r_valid;
    t_req_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

### rtl/deq_store.sv
// Entry store of the double-ended queue: shift-register slots, occupancy,
// cached back entry and the per-request update logic. Depends on deq_pkg.
module deq_store
    import deq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_advance,
    input  t_req_item i_item,
    output t_result   o_result
);

    // slot 0 is the front, slot occupancy-1 the back
    logic signed [DATA_W-1:0] r_slots [DEPTH];
    logic signed [DATA_W-1:0] n_slots [DEPTH];
    logic signed [DATA_W-1:0] r_last;
    logic signed [DATA_W-1:0] n_last;
    logic [CNT_W-1:0]         r_occ;
    logic [CNT_W-1:0]         n_occ;
    logic [IDX_W-1:0]         rd_idx;
    logic                     is_full;
    logic                     is_empty;
    t_status                  status;
    logic signed [DATA_W-1:0] removed;

    assign is_full  = (r_occ == CNT_W'(DEPTH));
    assign is_empty = (r_occ == '0);
    // entry just below the back, needed only when popping the back
    assign rd_idx   = IDX_W'(r_occ - CNT_W'(2));

    always_comb begin
        n_slots = r_slots;
        n_occ   = r_occ;
        n_last  = r_last;
        status  = ST_DONE;
        removed = '0;
        unique case (i_item.req) inside
            REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
                if (is_full) begin
                    status = ST_FULL;
                end else begin
                    n_occ = r_occ + CNT_W'(1);
                    if (i_item.req == REQ_PUSH_BACK) begin
                        n_slots[IDX_W'(r_occ)] = i_item.value;
                        n_last                 = i_item.value;
                    end else begin
                        for (int i = 1; i < DEPTH; i++) begin
                            n_slots[i] = r_slots[i-1];
                        end
                        n_slots[0] = i_item.value;
                        n_last     = is_empty ? i_item.value : r_last;
                    end
                end
            end
            REQ_POP_FRONT: begin
                if (is_empty) begin
                    status = ST_EMPTY;
                end else begin
                    removed = r_slots[0];
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        n_slots[i] = r_slots[i+1];
                    end
                    n_occ = r_occ - CNT_W'(1);
                end
            end
            REQ_POP_BACK: begin
                if (is_empty) begin
                    status = ST_EMPTY;
                end else begin
                    removed = r_last;
                    n_last  = r_slots[rd_idx];
                    n_occ   = r_occ - CNT_W'(1);
                end
            end
            default: begin
                status = ST_DONE;
            end
        endcase
    end

    always_comb begin
        o_result.status  = status;
        o_result.removed = removed;
        o_result.front   = (n_occ == '0) ? '0 : n_slots[0];
        o_result.last    = (n_occ == '0) ? '0 : n_last;
        o_result.count   = n_occ;
        o_result.empty   = (n_occ == '0);
        o_result.full    = (n_occ == CNT_W'(DEPTH));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_advance) begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_slots <= n_slots;
            r_last  <= n_last;
        end
    end

endmodule

### rtl/deq_out_reg.sv
// Result register of the double-ended queue: holds one result item
// until the receiver takes it. Depends on deq_pkg.
module deq_out_reg
    import deq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

### rtl/deq_checker.sv
// Port-level checker for the double-ended queue, bound to the top level.
// Depends on deq_pkg and double_ended_queue_defines.svh.
`include "double_ended_queue_defines.svh"

module deq_checker
    import deq_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic [DATA_W-1:0]     i_s_tdata,
    input logic [1:0]            i_s_tuser,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata,
    input logic [1:0]            o_m_tuser
);

    logic [CNT_W-1:0]  count;
    logic [DATA_W-1:0] removed_val;
    logic [DATA_W-1:0] front_val;
    logic [DATA_W-1:0] last_val;
    logic              empty_flag;
    logic              full_flag;
    logic              empty_ok;
    logic              full_ok;
    logic              refused;

    assign count       = o_m_tdata[COUNT_LSB +: CNT_W];
    assign removed_val = o_m_tdata[REMOVED_LSB +: DATA_W];
    assign front_val   = o_m_tdata[FRONT_LSB +: DATA_W];
    assign last_val    = o_m_tdata[LAST_LSB +: DATA_W];
    assign empty_flag  = o_m_tdata[EMPTY_BIT];
    assign full_flag   = o_m_tdata[FULL_BIT];
    // flags must agree with the reported entry count
    assign empty_ok    = (empty_flag == (count == '0));
    assign full_ok     = (full_flag == (count == CNT_W'(DEPTH)));
    assign refused     = (o_m_tuser == ST_FULL) || (o_m_tuser == ST_EMPTY);

    `DEQ_ASSERT_RST(a_reset_clears_out, !i_rst_n |=> !o_m_tvalid)

    `DEQ_ASSERT(a_stall_holds, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))

    `DEQ_ASSERT(a_flags_match_count, o_m_tvalid |-> empty_ok && full_ok)

    `DEQ_ASSERT(a_empty_reads_zero, o_m_tvalid && empty_flag |-> front_val == '0 && last_val == '0)

    `DEQ_ASSERT(a_refused_removes_nothing, o_m_tvalid && refused |-> removed_val == '0)

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);

### bench/double_ended_queue_test.sv
// Self-checking bench for the double-ended queue: directed corner items, then
// biased random push/pop traffic with random stalls on both streams.
// Depends on deq_pkg and the double_ended_queue RTL.
module double_ended_queue_test;
    import deq_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 400;
    localparam int IDLE_PCT     = 19;
    localparam int DRAIN_CYCLES = 8;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [DATA_W-1:0]     i_s_tdata  = '0;         // [31:0] push_value
    logic [1:0]            i_s_tuser  = 2'b00;      // [1:0] req_type
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    // [31:0] removed, [63:32] front, [95:64] last, [100:96] count,
    // [101] empty, [102] full, rest zero
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic [1:0]            o_m_tuser;               // [1:0] status

    bit steady      = 1'b0;    // both sides stall-free while set
    int cycle_count = 0;

    // Shadow deque: mirrors the stored entries and queues the result each
    // accepted request should produce.
    class deque_scoreboard;
        logic signed [DATA_W-1:0] entries[$];
        t_result                  results_due[$];
        int                       errors = 0;

        function void note_request(t_req req, logic signed [DATA_W-1:0] value);
            t_result want;
            want        = '0;
            want.status = ST_DONE;
            case (req)
                REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
                    if (entries.size() >= DEPTH)
                        want.status = ST_FULL;
                    else if (req == REQ_PUSH_BACK)
                        entries.push_back(value);
                    else
                        entries.push_front(value);
                end
                default: begin
                    if (entries.size() == 0)
                        want.status = ST_EMPTY;
                    else if (req == REQ_POP_FRONT)
                        want.removed = entries.pop_front();
                    else
                        want.removed = entries.pop_back();
                end
            endcase
            // front/last read zero once the deque runs dry
            if (entries.size() != 0) begin
                want.front = entries[0];
                want.last  = entries[$];
            end
            want.count = CNT_W'(entries.size());
            want.empty = (entries.size() == 0);
            want.full  = (entries.size() >= DEPTH);
            results_due.push_back(want);
        endfunction

        task report_mismatch(string field, logic [DATA_W-1:0] got,
                             logic [DATA_W-1:0] want);
            $display("mismatch at %0t: %s got %0h want %0h", $time, field, got, want);
            errors++;
        endtask

        task check_result(logic [OUT_DATA_W-1:0] data, logic [1:0] user);
            t_result want;
            if (results_due.size() == 0) begin
                report_mismatch("unexpected item", data[DATA_W-1:0], '0);
                return;
            end
            want = results_due.pop_front();
            if (user !== want.status)
                report_mismatch("status", DATA_W'(user), DATA_W'(want.status));
            if (data[REMOVED_LSB +: DATA_W] !== want.removed)
                report_mismatch("removed", data[REMOVED_LSB +: DATA_W], want.removed);
            if (data[FRONT_LSB +: DATA_W] !== want.front)
                report_mismatch("front", data[FRONT_LSB +: DATA_W], want.front);
            if (data[LAST_LSB +: DATA_W] !== want.last)
                report_mismatch("last", data[LAST_LSB +: DATA_W], want.last);
            if (data[COUNT_LSB +: CNT_W] !== want.count)
                report_mismatch("count", DATA_W'(data[COUNT_LSB +: CNT_W]),
                                DATA_W'(want.count));
            if (data[EMPTY_BIT] !== want.empty)
                report_mismatch("empty", DATA_W'(data[EMPTY_BIT]), DATA_W'(want.empty));
            if (data[FULL_BIT] !== want.full)
                report_mismatch("full", DATA_W'(data[FULL_BIT]), DATA_W'(want.full));
        endtask
    endclass

    deque_scoreboard sb = new();

    double_ended_queue u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Receiver back-pressure, dropped entirely during the steady stretch
    always @(posedge i_clk) begin
        i_m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Both handshakes sampled at the edge; results are checked before the
    // request of the same edge is noted, as a result always trails its request.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready)
                sb.check_result(o_m_tdata, o_m_tuser);
            if (i_s_tvalid && o_s_tready)
                sb.note_request(t_req'(i_s_tuser), i_s_tdata);
        end
    end

    // Offers one request item, with a random idle gap ahead of it, and returns
    // at the edge where it is taken.
    task automatic send_request(t_req req, logic [DATA_W-1:0] value);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        i_s_tuser  <= req;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // Mostly uniform values, with the signed extremes, zero and minus one mixed in
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        bit   filling;
        int   roll;
        t_req req;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty deque: both pops refused, value ignored
        send_request(REQ_POP_FRONT, '1);
        send_request(REQ_POP_BACK, 32'h8000_0000);
        // signed extremes at both ends, then fill to the brim from both sides
        send_request(REQ_PUSH_BACK, 32'h7FFF_FFFF);
        send_request(REQ_PUSH_FRONT, 32'h8000_0000);
        for (int i = 2; i < DEPTH; i++)
            send_request((i % 2) ? REQ_PUSH_FRONT : REQ_PUSH_BACK, pick_value());
        // full: both pushes refused
        send_request(REQ_PUSH_BACK, 32'h1234_5678);
        send_request(REQ_PUSH_FRONT, '0);
        send_request(REQ_POP_FRONT, '0);
        send_request(REQ_POP_BACK, '0);

        // Random walk on occupancy: lean towards filling until full, then
        // towards draining until empty, with odd reversals and some noise.
        filling = 1'b0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            steady = (i >= 150 && i < 250);
            if (sb.entries.size() >= DEPTH)
                filling = 1'b0;
            else if (sb.entries.size() == 0)
                filling = 1'b1;
            else if ($urandom_range(19) == 0)
                filling = !filling;
            roll = $urandom_range(99);
            if (roll < 8)
                req = t_req'($urandom_range(3));
            else if ((roll < 72) == filling)
                req = $urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
            else
                req = $urandom_range(1) ? REQ_POP_FRONT : REQ_POP_BACK;
            send_request(req, pick_value());
        end
        i_s_tvalid <= 1'b0;
        steady = 1'b0;

        while (sb.results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
